// ===== sv/v4n_pkg.sv =====
// shared types and constants for the four-component vector normalizer
package v4n_pkg;

	localparam int VecDim   = 4;
	localparam int FracBits = 14;
	localparam int QBits    = FracBits + 1;
	localparam int SumBits  = 33;
	localparam int SqBits   = 31;
	localparam int TgtBits  = SqBits + 2 * FracBits;
	localparam int QsBits   = QBits + SumBits;
	localparam int CandBits = 65;

	typedef struct packed {
		logic [TgtBits-1:0] tgt;
		logic [QBits-1:0]   q;
		logic [TgtBits-1:0] p;
		logic [QsBits-1:0]  qs;
	} lane_t;

	typedef struct packed {
		logic [SumBits-1:0] sum;
		logic [VecDim-1:0]  neg;
		logic               zero;
		lane_t [VecDim-1:0] lane;
	} stage_t;

endpackage

// ===== sv/v4n_root_step.sv =====
// one pipeline stage that settles one quotient bit on all four lanes
module v4n_root_step #(
	parameter int BIT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            d_valid,
	input  v4n_pkg::stage_t d,
	output logic            q_valid,
	output v4n_pkg::stage_t q
);

	v4n_pkg::stage_t nxt;
	logic [v4n_pkg::CandBits-1:0] cand [v4n_pkg::VecDim];

	// cand^2*S = q^2*S + (q*S)<<(b+1) + S<<2b
	always_comb begin
		nxt = d;
		for (int i = 0; i < v4n_pkg::VecDim; i++) begin
			cand[i] = v4n_pkg::CandBits'(d.lane[i].p)
				+ (v4n_pkg::CandBits'(d.lane[i].qs) << (BIT + 1))
				+ (v4n_pkg::CandBits'(d.sum) << (2 * BIT));
			if (cand[i] <= v4n_pkg::CandBits'(d.lane[i].tgt)) begin
				nxt.lane[i].q  = d.lane[i].q | (v4n_pkg::QBits'(1) << BIT);
				nxt.lane[i].p  = cand[i][v4n_pkg::TgtBits-1:0];
				nxt.lane[i].qs = d.lane[i].qs + (v4n_pkg::QsBits'(d.sum) << BIT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (adv) begin
			q_valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q <= nxt;
		end
	end

endmodule

// ===== sv/vec4_normalize_core.sv =====
// top level of the four-component vector normalizer
// Scales a signed 16-bit four-component vector to unit length, giving each
// component as Q1.14 truncated toward zero; an all-zero vector gives zeros
// and zero_length. One beat is accepted every cycle while in_stall is low.
// One stage squares the magnitudes, one sums them, fifteen stages settle
// one quotient bit each by compare against a running product, and one
// registers the signed result. in_stall follows out_stall whenever a
// result is held, and the whole pipeline freezes together.
module vec4_normalize_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] comp_x,
	input  logic [15:0] comp_y,
	input  logic [15:0] comp_z,
	input  logic [15:0] comp_w,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] unit_x,
	output logic [15:0] unit_y,
	output logic [15:0] unit_z,
	output logic [15:0] unit_w,
	output logic        zero_length
);

	localparam int NSteps = v4n_pkg::QBits;

	logic adv;
	logic [15:0] comp [v4n_pkg::VecDim];
	logic [16:0] mag [v4n_pkg::VecDim];

	logic                        valid_s1;
	logic [v4n_pkg::SqBits-1:0]  sq_s1 [v4n_pkg::VecDim];
	logic [v4n_pkg::VecDim-1:0]  neg_s1;

	logic            valid_s2;
	v4n_pkg::stage_t data_s2;
	v4n_pkg::stage_t init;

	logic            v_chain [NSteps+1];
	v4n_pkg::stage_t d_chain [NSteps+1];

	logic [15:0] res [v4n_pkg::VecDim];

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign comp[0] = comp_x;
	assign comp[1] = comp_y;
	assign comp[2] = comp_z;
	assign comp[3] = comp_w;

	always_comb begin
		for (int i = 0; i < v4n_pkg::VecDim; i++) begin
			mag[i] = comp[i][15] ? 17'(-$signed({comp[i][15], comp[i]}))
				: {1'b0, comp[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < v4n_pkg::VecDim; i++) begin
				sq_s1[i]  <= v4n_pkg::SqBits'(34'(mag[i]) * 34'(mag[i]));
				neg_s1[i] <= comp[i][15];
			end
		end
	end

	always_comb begin
		init.sum  = v4n_pkg::SumBits'(sq_s1[0]) + v4n_pkg::SumBits'(sq_s1[1])
			+ v4n_pkg::SumBits'(sq_s1[2]) + v4n_pkg::SumBits'(sq_s1[3]);
		init.neg  = neg_s1;
		init.zero = (init.sum == '0);
		for (int i = 0; i < v4n_pkg::VecDim; i++) begin
			init.lane[i].tgt = v4n_pkg::TgtBits'(sq_s1[i]) << (2 * v4n_pkg::FracBits);
			init.lane[i].q   = '0;
			init.lane[i].p   = '0;
			init.lane[i].qs  = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= init;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign v_chain[0] = valid_s2;
	assign d_chain[0] = data_s2;

	// most significant quotient bit first
	for (genvar g = 0; g < NSteps; g++) begin : g_step
		v4n_root_step #(
			.BIT(NSteps - 1 - g)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.d_valid(v_chain[g]),
			.d      (d_chain[g]),
			.q_valid(v_chain[g+1]),
			.q      (d_chain[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < v4n_pkg::VecDim; i++) begin
			if (d_chain[NSteps].zero) begin
				res[i] = '0;
			end else if (d_chain[NSteps].neg[i]) begin
				res[i] = 16'(-$signed({1'b0, d_chain[NSteps].lane[i].q}));
			end else begin
				res[i] = {1'b0, d_chain[NSteps].lane[i].q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_chain[NSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_x      <= res[0];
			unit_y      <= res[1];
			unit_z      <= res[2];
			unit_w      <= res[3];
			zero_length <= d_chain[NSteps].zero;
		end
	end

endmodule
